FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port checker of the gyro integrator.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or condition, off while reset is low.
`define GBI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define GBI_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/gbi_pkg.sv
// Shared types, constants and helper functions of the gyro bias integrator.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package gbi_pkg;

  localparam int MAX_AXES  = 3;
  localparam int AXES      = 3;

  localparam int RAW_W     = 16;
  localparam int BIAS_W    = 16;
  localparam int SUM_W     = 33;
  localparam int MAG_W     = 32;
  localparam int CNT_W     = 16;
  localparam int SENS_W    = 10;
  localparam int DT_W      = 10;
  localparam int CORR_W    = 27;
  localparam int INC_W     = 38;
  localparam int ACC_W     = 37;
  localparam int ANG_W     = 32;
  localparam int RANGE_W   = 8;
  localparam int ELAPSED_W = 16;
  localparam int CMD_W     = 2;

  localparam int RED_STEPS = 5;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;

  // Full turn and snap level in 1/8 micro-degree
  localparam logic [ACC_W-1:0] FULL_TURN  = ACC_W'(64'd2880000000);
  localparam logic [ACC_W-1:0] SNAP_LEVEL = ACC_W'(64'd2879992000);
  // Bias that makes any angle plus increment positive: 16 full turns
  localparam logic [ACC_W-1:0] RED_OFFSET = FULL_TURN << (RED_STEPS - 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [CORR_W-1:0] RATE_MAX = CORR_W'(36700160);
  localparam logic signed [CORR_W-1:0] RATE_MIN = -RATE_MAX;

  // Sensitivity per LSB in 1/8 mdps
  localparam logic [SENS_W-1:0] SENS_125  = SENS_W'(35);
  localparam logic [SENS_W-1:0] SENS_250  = SENS_W'(70);
  localparam logic [SENS_W-1:0] SENS_500  = SENS_W'(140);
  localparam logic [SENS_W-1:0] SENS_1000 = SENS_W'(280);
  localparam logic [SENS_W-1:0] SENS_2000 = SENS_W'(560);

  localparam logic [RANGE_W-1:0] RANGE_RESET  = RANGE_W'(4);
  localparam logic [CNT_W-1:0]   CAL_N_RESET  = CNT_W'(300);
  localparam logic [DT_W-1:0]    DT_LIM_RESET = DT_W'(50);

  typedef enum logic [CMD_W-1:0] {
    CMD_INTEGRATE  = 2'd0,
    CMD_CAL_SAMPLE = 2'd1,
    CMD_RESTART    = 2'd2,
    CMD_IGNORE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RANGE     = 2'd0,
    REG_CAL_COUNT = 2'd1,
    REG_DT_LIMIT  = 2'd2,
    REG_AXIS_NEG  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ADD,
    ST_RED,
    ST_SNAP,
    ST_CAL,
    ST_CHK,
    ST_DIV,
    ST_BIAS,
    ST_ZERO,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  range_code;
    logic [CNT_W-1:0]    cal_sample_count;
    logic [DT_W-1:0]     dt_limit;
    logic [MAX_AXES-1:0] axis_negate;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              scale;
    logic              add;
    logic              red;
    logic [STEP_W-1:0] step;
    logic              snap;
    logic              zero;
    logic              cal_acc;
    logic              div_start;
    logic              div_step;
    logic              bias_wr;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cal_done;
  } dp_stat_t;

  function automatic logic [SENS_W-1:0] sensitivity(input logic [RANGE_W-1:0] range_code);
    logic [SENS_W-1:0] s;
    if (range_code[1]) begin
      s = SENS_125;
    end else begin
      unique case (range_code[3:2])
        2'd0:    s = SENS_250;
        2'd1:    s = SENS_500;
        2'd2:    s = SENS_1000;
        default: s = SENS_2000;
      endcase
    end
    return s;
  endfunction

  // Multiple of a full turn taken off at reduction step k: 16, 8, 4, 2, 1 turns
  function automatic logic [ACC_W-1:0] red_multiple(input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] sh;
    sh = STEP_W'(RED_STEPS - 1) - step;
    return FULL_TURN << sh;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gbi_regs.sv
// APB-style configuration registers of the gyro bias integrator.
// Depends on gbi_pkg for the register map and the config struct.
`default_nettype none

module gbi_regs
  import gbi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_RANGE:     cfg_nxt.range_code       = cfg_pwdata[RANGE_W-1:0];
        REG_CAL_COUNT: cfg_nxt.cal_sample_count = cfg_pwdata[CNT_W-1:0];
        REG_DT_LIMIT:  cfg_nxt.dt_limit         = cfg_pwdata[DT_W-1:0];
        REG_AXIS_NEG:  cfg_nxt.axis_negate      = cfg_pwdata[MAX_AXES-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_code       <= RANGE_RESET;
      cfg_r.cal_sample_count <= CAL_N_RESET;
      cfg_r.dt_limit         <= DT_LIM_RESET;
      cfg_r.axis_negate      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_RANGE:     cfg_prdata = DATA_W'(cfg_r.range_code);
      REG_CAL_COUNT: cfg_prdata = DATA_W'(cfg_r.cal_sample_count);
      REG_DT_LIMIT:  cfg_prdata = DATA_W'(cfg_r.dt_limit);
      REG_AXIS_NEG:  cfg_prdata = DATA_W'(cfg_r.axis_negate);
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbi_lane.sv
// One axis of the datapath: rate correction, angle integration with wrap,
// calibration sum and bit-serial bias division. Depends on gbi_pkg.
`default_nettype none

module gbi_lane
  import gbi_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  input  wire logic signed [RAW_W-1:0] raw_in,
  input  wire logic                    fresh,
  input  wire logic [SENS_W-1:0]       sens,
  input  wire logic [DT_W-1:0]         dt,
  input  wire logic                    negate,
  input  wire logic [CNT_W-1:0]        divisor,
  output logic      [ANG_W-1:0]        angle,
  output logic signed [CORR_W-1:0]     corr
);

  // Architectural state
  logic        [ANG_W-1:0]  angle_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Working registers
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [CORR_W-1:0] corr_r;
  logic signed [INC_W-1:0]  inc_r;
  logic        [ACC_W-1:0]  acc_r;
  logic        [MAG_W-1:0]  mag_r;
  logic        [CNT_W-1:0]  rem_r;
  logic                     neg_r;

  logic signed [RAW_W:0]       diff;
  logic signed [CORR_W:0]      prod1;
  logic signed [INC_W-1:0]     prod2;
  logic signed [ACC_W+1:0]     add_sum;
  logic        [ACC_W-1:0]     red_m;
  logic signed [SUM_W-1:0]     raw_ext;
  logic signed [SUM_W-1:0]     sum_abs;
  logic        [CNT_W:0]       rem_sh;
  logic        [CNT_W:0]       rem_sub;
  logic        [BIAS_W-1:0]    quot;

  assign diff    = $signed({raw_r[RAW_W-1], raw_r}) - $signed({bias_r[BIAS_W-1], bias_r});
  assign prod1   = diff * $signed({1'b0, sens});
  assign prod2   = corr_r * $signed({1'b0, dt});
  assign add_sum = $signed({{(ACC_W+2-ANG_W){1'b0}}, angle_r})
                 + $signed({{(ACC_W+2-INC_W){inc_r[INC_W-1]}}, inc_r})
                 + $signed({2'b00, RED_OFFSET});
  assign red_m   = red_multiple(cmd.step);
  assign raw_ext = SUM_W'(raw_r);
  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign rem_sh  = {rem_r, mag_r[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quot    = mag_r[BIAS_W-1:0];

  // Working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r <= raw_in;
    end
    if (cmd.mul) begin
      corr_r <= prod1[CORR_W-1:0];
    end
    if (cmd.scale) begin
      inc_r <= negate ? -prod2 : prod2;
    end
    if (cmd.add) begin
      acc_r <= add_sum[ACC_W-1:0];
    end else if (cmd.red) begin
      if (acc_r >= red_m) begin
        acc_r <= acc_r - red_m;
      end
    end
    if (cmd.div_start) begin
      mag_r <= sum_abs[MAG_W-1:0];
      rem_r <= '0;
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.div_step) begin
      // restoring step: one quotient bit a cycle
      if (!rem_sub[CNT_W]) begin
        rem_r <= rem_sub[CNT_W-1:0];
        mag_r <= {mag_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CNT_W-1:0];
        mag_r <= {mag_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  // Architectural state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      sum_r   <= '0;
    end else begin
      if (cmd.zero) begin
        angle_r <= '0;
      end else if (cmd.snap) begin
        angle_r <= (acc_r >= SNAP_LEVEL) ? '0 : acc_r[ANG_W-1:0];
      end
      if (cmd.zero) begin
        sum_r <= '0;
      end else if (cmd.cal_acc) begin
        sum_r <= fresh ? raw_ext : sum_r + raw_ext;
      end
      if (cmd.bias_wr) begin
        bias_r <= neg_r ? -$signed(quot) : $signed(quot);
      end
    end
  end

  assign angle = angle_r;
  assign corr  = corr_r;

endmodule

`default_nettype wire

FILE: rtl/core/gbi_dp.sv
// Datapath of the gyro bias integrator: per-axis lanes, calibration count,
// input capture and the result register. Depends on gbi_pkg and gbi_lane.
`default_nettype none

module gbi_dp
  import gbi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire dp_cmd_t                  cmd,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [RAW_W-1:0]  in_rate [MAX_AXES],
  input  wire logic [ELAPSED_W-1:0]     in_elapsed_ms,
  output dp_stat_t                      stat,
  output logic [ANG_W-1:0]              out_angle [MAX_AXES],
  output logic signed [CORR_W-1:0]      out_corr [MAX_AXES],
  output logic                          out_calibrating
);

  logic [CNT_W-1:0] cal_count_r;
  logic             cal_active_r;
  cmd_t             cmd_r;
  logic [DT_W-1:0]  dt_r;

  logic [ANG_W-1:0]         ang_r [MAX_AXES];
  logic signed [CORR_W-1:0] corr_out_r [MAX_AXES];
  logic                     calib_r;

  logic [ANG_W-1:0]         lane_angle [MAX_AXES];
  logic signed [CORR_W-1:0] lane_corr  [MAX_AXES];
  logic [SENS_W-1:0]        sens;
  logic [CNT_W-1:0]         target;
  logic [CNT_W-1:0]         cnt_base;

  assign sens      = sensitivity(cfg.range_code);
  assign target    = (cfg.cal_sample_count == '0) ? CNT_W'(1) : cfg.cal_sample_count;
  assign cnt_base  = cal_active_r ? cal_count_r : '0;
  assign stat.cal_done = (cal_count_r >= target);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= cmd_t'(in_command);
      dt_r  <= (in_elapsed_ms < ELAPSED_W'(cfg.dt_limit)) ? in_elapsed_ms[DT_W-1:0]
                                                          : cfg.dt_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r  <= '0;
      cal_active_r <= 1'b0;
    end else begin
      if (cmd.zero) begin
        cal_count_r  <= '0;
        cal_active_r <= 1'b1;
      end else if (cmd.cal_acc) begin
        // saturate the sample count
        cal_count_r  <= (cnt_base == CNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
        cal_active_r <= 1'b1;
      end else if (cmd.bias_wr) begin
        cal_active_r <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_lane
      gbi_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .raw_in  (in_rate[i]),
        .fresh   (!cal_active_r),
        .sens    (sens),
        .dt      (dt_r),
        .negate  (cfg.axis_negate[i]),
        .divisor (cal_count_r),
        .angle   (lane_angle[i]),
        .corr    (lane_corr[i])
      );
    end else begin : g_none
      assign lane_angle[i] = '0;
      assign lane_corr[i]  = '0;
    end

    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        ang_r[i]      <= lane_angle[i];
        corr_out_r[i] <= (cmd_r == CMD_INTEGRATE) ? lane_corr[i] : '0;
      end
    end

    assign out_angle[i] = ang_r[i];
    assign out_corr[i]  = corr_out_r[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      calib_r <= cal_active_r;
    end
  end

  assign out_calibrating = calib_r;

endmodule

`default_nettype wire

FILE: rtl/core/gbi_ctrl.sv
// Controller of the gyro bias integrator: sequences the datapath per command
// and owns both handshakes. Depends on gbi_pkg.
`default_nettype none

module gbi_ctrl
  import gbi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = step_r;
    in_ready      = 1'b0;

    // a waiting result leaves on its transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (cmd_t'(in_command))
            CMD_INTEGRATE:  state_nxt = ST_MUL;
            CMD_CAL_SAMPLE: state_nxt = ST_CAL;
            CMD_RESTART:    state_nxt = ST_ZERO;
            CMD_IGNORE:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.red  = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RED_STEPS - 1)) begin
          state_nxt = ST_SNAP;
        end
      end
      ST_SNAP: begin
        cmd.snap  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_CAL: begin
        cmd.cal_acc = 1'b1;
        state_nxt   = ST_CHK;
      end
      ST_CHK: begin
        if (stat.cal_done) begin
          cmd.div_start = 1'b1;
          step_nxt      = '0;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: begin
        cmd.bias_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_ZERO: begin
        cmd.zero  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/gyro_bias_integrate_wrap.sv
// Top level of the gyro bias integrator: config registers, controller and datapath.
// Depends on gbi_pkg, gbi_regs, gbi_ctrl and gbi_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command with a three-axis raw
//   sample and the elapsed milliseconds. Output channel (out_valid/out_ready)
//   returns one result per command: the three angles after the step, the
//   bias-corrected rates (zero unless integrating) and the calibrating flag.
//   Config is an APB-style port (cfg_*), pready always high; write it only while
//   the block is idle.
// Steps after accept: integrate runs multiply, scale, add, five reduction
//   steps of the angle modulo a full turn and snap; a calibration sample adds
//   to the sum and checks the count, and on the closing sample a bit-serial
//   divider per axis forms the bias; zero/restart clears the angles and sums;
//   an ignored command goes straight to the result.
// Flow: one item at a time; the next item is accepted in the cycle after
//   the result is loaded.
// Reset: angles, sums, count, bias clear; registers take their reset values.
// Stall: a result waits in the output register while the next item is taken
//   and worked on; that item holds in its last step until the register frees.
`default_nettype none

module gyro_bias_integrate_wrap
  import gbi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [RAW_W-1:0]  in_rate_x,
  input  wire logic signed [RAW_W-1:0]  in_rate_y,
  input  wire logic signed [RAW_W-1:0]  in_rate_z,
  input  wire logic [ELAPSED_W-1:0]     in_elapsed_ms,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [ANG_W-1:0]              out_roll_angle,
  output logic [ANG_W-1:0]              out_pitch_angle,
  output logic [ANG_W-1:0]              out_yaw_angle,
  output logic signed [CORR_W-1:0]      out_corrected_x,
  output logic signed [CORR_W-1:0]      out_corrected_y,
  output logic signed [CORR_W-1:0]      out_corrected_z,
  output logic                          out_calibrating,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [ADDR_W-1:0]        cfg_paddr,
  input  wire logic [DATA_W-1:0]        cfg_pwdata,
  output logic      [DATA_W-1:0]        cfg_prdata,
  output logic                          cfg_pready
);

  cfg_t                     cfg;
  dp_cmd_t                  dp_cmd;
  dp_stat_t                 dp_stat;
  logic signed [RAW_W-1:0]  rate [MAX_AXES];
  logic [ANG_W-1:0]         angle [MAX_AXES];
  logic signed [CORR_W-1:0] corr [MAX_AXES];

  assign rate[0] = in_rate_x;
  assign rate[1] = in_rate_y;
  assign rate[2] = in_rate_z;

  gbi_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gbi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  gbi_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (dp_cmd),
    .in_command      (in_command),
    .in_rate         (rate),
    .in_elapsed_ms   (in_elapsed_ms),
    .stat            (dp_stat),
    .out_angle       (angle),
    .out_corr        (corr),
    .out_calibrating (out_calibrating)
  );

  assign out_roll_angle  = angle[0];
  assign out_pitch_angle = angle[1];
  assign out_yaw_angle   = angle[2];
  assign out_corrected_x = corr[0];
  assign out_corrected_y = corr[1];
  assign out_corrected_z = corr[2];

endmodule

`default_nettype wire

FILE: rtl/core/gbi_checker.sv
// Port-level checks of the gyro bias integrator, bound to the top level.
// Depends on gbi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gbi_checker
  import gbi_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [ANG_W-1:0]         out_roll_angle,
  input wire logic [ANG_W-1:0]         out_pitch_angle,
  input wire logic [ANG_W-1:0]         out_yaw_angle,
  input wire logic signed [CORR_W-1:0] out_corrected_x,
  input wire logic signed [CORR_W-1:0] out_corrected_y,
  input wire logic signed [CORR_W-1:0] out_corrected_z
);

  // Angles are wrapped and snapped below 359.999 degrees
  `GBI_ASSERT(a_angle_range, clk, rst_n, out_valid |-> (ACC_W'(out_roll_angle) < SNAP_LEVEL && ACC_W'(out_pitch_angle) < SNAP_LEVEL && ACC_W'(out_yaw_angle) < SNAP_LEVEL), "angle outside wrapped range")

  // Corrected rates stay within full scale times the largest sensitivity
  `GBI_ASSERT(a_rate_range, clk, rst_n, out_valid |-> (out_corrected_x <= RATE_MAX && out_corrected_x >= RATE_MIN && out_corrected_y <= RATE_MAX && out_corrected_y >= RATE_MIN && out_corrected_z <= RATE_MAX && out_corrected_z >= RATE_MIN), "corrected rate out of range")

  // One item at a time: after a transfer in, the input closes
  `GBI_ASSERT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "input open right after a transfer")

  // A stalled result holds: valid stays up and the roll angle and X rate keep their values
  `GBI_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_roll_angle) && $stable(out_corrected_x)), "stalled result changed")

endmodule

bind gyro_bias_integrate_wrap gbi_checker u_gbi_checker (.*);

`default_nettype wire

FILE: tb/sv/gyro_bias_integrate_wrap_checker.sv
`timescale 1ns / 1ps
// Checker for gyro_bias_integrate_wrap: tracks config writes, predicts each result
// from the accepted commands and compares it with what the block returns. Needs gbi_pkg.
module gyro_bias_integrate_wrap_checker
  import gbi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [RAW_W-1:0]  in_rate_x,
  input  logic signed [RAW_W-1:0]  in_rate_y,
  input  logic signed [RAW_W-1:0]  in_rate_z,
  input  logic [ELAPSED_W-1:0]     in_elapsed_ms,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ANG_W-1:0]         out_roll_angle,
  input  logic [ANG_W-1:0]         out_pitch_angle,
  input  logic [ANG_W-1:0]         out_yaw_angle,
  input  logic signed [CORR_W-1:0] out_corrected_x,
  input  logic signed [CORR_W-1:0] out_corrected_y,
  input  logic signed [CORR_W-1:0] out_corrected_z,
  input  logic                     out_calibrating,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic                     cfg_pready,
  input  logic [ADDR_W-1:0]        cfg_paddr,
  input  logic [DATA_W-1:0]        cfg_pwdata,
  output int                       mismatches,
  output int                       outstanding
);

  // Angles in 1/8 micro-degree
  localparam longint TURN_UNITS = 64'd2880000000;
  localparam longint SNAP_UNITS = 64'd2879992000;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic [ANG_W-1:0]  roll;
    logic [ANG_W-1:0]  pitch;
    logic [ANG_W-1:0]  yaw;
    logic [CORR_W-1:0] rate_x;
    logic [CORR_W-1:0] rate_y;
    logic [CORR_W-1:0] rate_z;
    logic              calibrating;
  } sample_result_t;

  logic [RANGE_W-1:0]  cfg_range;
  logic [CNT_W-1:0]    cfg_cal_n;
  logic [DT_W-1:0]     cfg_dt_lim;
  logic [AXES-1:0]     cfg_neg;

  longint cal_sum [AXES];
  int     bias_lsb [AXES];
  longint heading [AXES];
  int     cal_n;
  bit     cal_on;
  int     errs;

  sample_result_t expected_results [$];

  function automatic int lsb_scale(input logic [RANGE_W-1:0] code);
    if (code[1]) return 35;
    case (code[3:2])
      2'd0:    return 70;
      2'd1:    return 140;
      2'd2:    return 280;
      default: return 560;
    endcase
  endfunction

  // Fold into one turn; anything within the last milli-degree reads as zero
  function automatic longint fold_turn(input longint a);
    longint r;
    r = a % TURN_UNITS;
    if (r < 0) r += TURN_UNITS;
    if (r >= SNAP_UNITS) r = 0;
    return r;
  endfunction

  function automatic string show(input sample_result_t r);
    return $sformatf("roll %0d pitch %0d yaw %0d rates %0d %0d %0d cal %0b",
                     r.roll, r.pitch, r.yaw, $signed(r.rate_x), $signed(r.rate_y),
                     $signed(r.rate_z), r.calibrating);
  endfunction

  task automatic advance_integrator(input cmd_t cmd, input logic signed [RAW_W-1:0] rx,
                                    input logic signed [RAW_W-1:0] ry,
                                    input logic signed [RAW_W-1:0] rz,
                                    input logic [ELAPSED_W-1:0] el);
    longint raw [AXES];
    longint corr [AXES];
    longint dt;
    longint inc;
    int target;
    int a;
    sample_result_t r;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    for (a = 0; a < AXES; a++) corr[a] = 0;
    case (cmd)
      CMD_INTEGRATE: begin
        dt = (el < cfg_dt_lim) ? el : cfg_dt_lim;
        for (a = 0; a < AXES; a++) begin
          corr[a] = (raw[a] - bias_lsb[a]) * lsb_scale(cfg_range);
          inc = corr[a] * dt;
          if (cfg_neg[a]) inc = -inc;
          heading[a] = fold_turn(heading[a] + inc);
        end
      end
      CMD_CAL_SAMPLE: begin
        target = (cfg_cal_n == 0) ? 1 : int'(cfg_cal_n);
        // a sample outside a collection opens a fresh one
        if (!cal_on) begin
          for (a = 0; a < AXES; a++) cal_sum[a] = 0;
          cal_n = 0;
          cal_on = 1'b1;
        end
        for (a = 0; a < AXES; a++) cal_sum[a] += raw[a];
        if (cal_n < 65535) cal_n++;
        if (cal_n >= target) begin
          for (a = 0; a < AXES; a++) bias_lsb[a] = int'(cal_sum[a] / longint'(cal_n));
          cal_on = 1'b0;
        end
      end
      CMD_RESTART: begin
        for (a = 0; a < AXES; a++) begin
          heading[a] = 0;
          cal_sum[a] = 0;
        end
        cal_n = 0;
        cal_on = 1'b1;
      end
      default: ;
    endcase
    r.roll        = ANG_W'(heading[0]);
    r.pitch       = ANG_W'(heading[1]);
    r.yaw         = ANG_W'(heading[2]);
    r.rate_x      = CORR_W'(corr[0]);
    r.rate_y      = CORR_W'(corr[1]);
    r.rate_z      = CORR_W'(corr[2]);
    r.calibrating = cal_on;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    sample_result_t seen;
    sample_result_t want;
    int a;
    if (!rst_n) begin
      cfg_range  = 8'd4;
      cfg_cal_n  = 16'd300;
      cfg_dt_lim = 10'd50;
      cfg_neg    = '0;
      for (a = 0; a < AXES; a++) begin
        cal_sum[a]  = 0;
        bias_lsb[a] = 0;
        heading[a]  = 0;
      end
      cal_n  = 0;
      cal_on = 1'b0;
      errs   = 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_RANGE:     cfg_range  = cfg_pwdata[RANGE_W-1:0];
          REG_CAL_COUNT: cfg_cal_n  = cfg_pwdata[CNT_W-1:0];
          REG_DT_LIMIT:  cfg_dt_lim = cfg_pwdata[DT_W-1:0];
          REG_AXIS_NEG:  cfg_neg    = cfg_pwdata[AXES-1:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        seen = {out_roll_angle, out_pitch_angle, out_yaw_angle, out_corrected_x,
                out_corrected_y, out_corrected_z, out_calibrating};
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: result transfer with nothing expected: %s", $time, show(seen));
        end else begin
          want = expected_results.pop_front();
          if (seen.roll !== want.roll || seen.pitch !== want.pitch ||
              seen.yaw !== want.yaw || seen.rate_x !== want.rate_x ||
              seen.rate_y !== want.rate_y || seen.rate_z !== want.rate_z ||
              seen.calibrating !== want.calibrating) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1)
        advance_integrator(cmd_t'(in_command), in_rate_x, in_rate_y, in_rate_z,
                           in_elapsed_ms);
    end
    mismatches  <= errs;
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_gyro_bias_integrate_wrap.sv
`timescale 1ns / 1ps
// Testbench top for gyro_bias_integrate_wrap: clock, reset, stimulus, config and verdict.
// Depends on gbi_pkg, the block and gyro_bias_integrate_wrap_checker.
module tb_gyro_bias_integrate_wrap;
  import gbi_pkg::*;

  localparam int TOTAL_ITEMS    = 870;
  localparam int TX_CALM_FROM   = 420;
  localparam int TX_CALM_TO     = 540;
  localparam int RX_CALM_FROM   = 600;
  localparam int RX_CALM_TO     = 700;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 21;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_command = CMD_INTEGRATE;
  logic signed [RAW_W-1:0] in_rate_x = '0;
  logic signed [RAW_W-1:0] in_rate_y = '0;
  logic signed [RAW_W-1:0] in_rate_z = '0;
  logic [ELAPSED_W-1:0]    in_elapsed_ms = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ANG_W-1:0]         out_roll_angle;
  logic [ANG_W-1:0]         out_pitch_angle;
  logic [ANG_W-1:0]         out_yaw_angle;
  logic signed [CORR_W-1:0] out_corrected_x;
  logic signed [CORR_W-1:0] out_corrected_y;
  logic signed [CORR_W-1:0] out_corrected_z;
  logic                     out_calibrating;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int outstanding;
  int sent = 0;

  always #5 clk = ~clk;

  gyro_bias_integrate_wrap u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_rate_x       (in_rate_x),
    .in_rate_y       (in_rate_y),
    .in_rate_z       (in_rate_z),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_corrected_x (out_corrected_x),
    .out_corrected_y (out_corrected_y),
    .out_corrected_z (out_corrected_z),
    .out_calibrating (out_calibrating),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  gyro_bias_integrate_wrap_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_rate_x       (in_rate_x),
    .in_rate_y       (in_rate_y),
    .in_rate_z       (in_rate_z),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_corrected_x (out_corrected_x),
    .out_corrected_y (out_corrected_y),
    .out_corrected_z (out_corrected_z),
    .out_calibrating (out_calibrating),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  function automatic logic signed [RAW_W-1:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return RAW_W'($urandom);
    if (r < 85) return RAW_W'(int'($urandom_range(0, 600)) - 300);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic send_item(input cmd_t cmd, input logic signed [RAW_W-1:0] x,
                           input logic signed [RAW_W-1:0] y,
                           input logic signed [RAW_W-1:0] z,
                           input logic [ELAPSED_W-1:0] el);
    while ((sent < TX_CALM_FROM || sent >= TX_CALM_TO) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_rate_x     <= x;
    in_rate_y     <= y;
    in_rate_z     <= z;
    in_elapsed_ms <= el;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random back-pressure, one long hold-off, one stretch always ready
  initial begin : result_sink
    int taken;
    int hold_left;
    bit held;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) taken++;
      if (!held && taken == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (taken >= RX_CALM_FROM && taken < RX_CALM_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int k;
    cmd_t cmd;
    logic [ELAPSED_W-1:0] el;
    logic [CNT_W-1:0] cnt;
    logic [DT_W-1:0] dtl;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings; the negative Y step lands in the snap band
    send_item(CMD_INTEGRATE, 16'sd1, -16'sd1, 16'sd0, 16'd10);
    send_item(CMD_IGNORE, pick_rate(), pick_rate(), pick_rate(), 16'hFFFF);
    send_item(CMD_CAL_SAMPLE, 16'sd20, -16'sd20, 16'sd3, 16'd5);
    send_item(CMD_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sd12345, 16'hFFFF);
    send_item(CMD_RESTART, pick_rate(), pick_rate(), pick_rate(), 16'd7);

    // Largest scale and time limit, all axes negated, single-sample bias
    settle();
    cfg_write(REG_RANGE, 32'h0C);
    cfg_write(REG_CAL_COUNT, 32'd1);
    cfg_write(REG_DT_LIMIT, 32'd1023);
    cfg_write(REG_AXIS_NEG, 32'd7);
    send_item(CMD_CAL_SAMPLE, 16'sh8000, 16'sh7FFF, -16'sd1, 16'd0);
    send_item(CMD_INTEGRATE, 16'sh7FFF, 16'sh8000, -16'sd1, 16'hFFFF);
    send_item(CMD_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd0);
    send_item(CMD_INTEGRATE, 16'sh8000, 16'sh7FFF, -16'sd1, 16'd1000);

    // Zero count acts as one, zero time limit freezes the angles
    settle();
    cfg_write(REG_RANGE, 32'h02);
    cfg_write(REG_CAL_COUNT, 32'd0);
    cfg_write(REG_DT_LIMIT, 32'd0);
    cfg_write(REG_AXIS_NEG, 32'd0);
    send_item(CMD_CAL_SAMPLE, 16'sd100, -16'sd100, 16'sd7, 16'd3);
    send_item(CMD_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sd1, 16'd500);

    // Long collection, then lower the count mid-way
    settle();
    cfg_write(REG_RANGE, 32'h00);
    cfg_write(REG_CAL_COUNT, 32'hFFFF);
    cfg_write(REG_DT_LIMIT, 32'd1000);
    cfg_write(REG_AXIS_NEG, 32'd5);
    send_item(CMD_INTEGRATE, 16'sd99, -16'sd50, 16'sd200, 16'd1);
    send_item(CMD_CAL_SAMPLE, -16'sd7, 16'sd5, 16'sh7FFF, 16'd1);
    send_item(CMD_CAL_SAMPLE, -16'sd7, 16'sd5, 16'sh7FFF, 16'd1);
    send_item(CMD_CAL_SAMPLE, -16'sd7, 16'sd5, 16'sh7FFF, 16'd1);
    settle();
    cfg_write(REG_RANGE, 32'hFF);
    cfg_write(REG_CAL_COUNT, 32'd2);
    cfg_write(REG_AXIS_NEG, 32'd2);
    // mean of -27 over four rounds toward zero
    send_item(CMD_CAL_SAMPLE, -16'sd6, 16'sd6, 16'sh7FFF, 16'd1);
    send_item(CMD_INTEGRATE, pick_rate(), pick_rate(), pick_rate(), 16'd999);
    send_item(CMD_IGNORE, pick_rate(), pick_rate(), pick_rate(), 16'd0);
    send_item(CMD_RESTART, pick_rate(), pick_rate(), pick_rate(), 16'd0);
    send_item(CMD_INTEGRATE, pick_rate(), pick_rate(), pick_rate(), 16'd40);

    settle();
    cfg_write(REG_RANGE, 32'h08);
    cfg_write(REG_CAL_COUNT, 32'd3);
    cfg_write(REG_DT_LIMIT, 32'd50);
    cfg_write(REG_AXIS_NEG, 32'd0);
    for (k = 0; k < 3; k++)
      send_item(CMD_CAL_SAMPLE, pick_rate(), pick_rate(), pick_rate(), 16'd10);

    // Random phases, each with fresh settings
    while (sent < TOTAL_ITEMS) begin
      settle();
      r = $urandom_range(0, 9);
      cnt = (r == 0) ? CNT_W'(0) : (r == 1) ? CNT_W'(16'hFFFF)
                                            : CNT_W'($urandom_range(1, 12));
      r = $urandom_range(0, 9);
      case (r)
        0:       dtl = DT_W'(0);
        1:       dtl = DT_W'(1);
        2:       dtl = DT_W'(1023);
        3:       dtl = DT_W'(1000);
        default: dtl = DT_W'($urandom_range(1, 200));
      endcase
      cfg_write(REG_RANGE, $urandom_range(0, 255));
      cfg_write(REG_CAL_COUNT, DATA_W'(cnt));
      cfg_write(REG_DT_LIMIT, DATA_W'(dtl));
      cfg_write(REG_AXIS_NEG, $urandom_range(0, 7));
      n = $urandom_range(20, 60);
      for (k = 0; k < n && sent < TOTAL_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      cmd = CMD_INTEGRATE;
        else if (r < 87) cmd = CMD_CAL_SAMPLE;
        else if (r < 93) cmd = CMD_RESTART;
        else             cmd = CMD_IGNORE;
        r = $urandom_range(0, 9);
        if (r < 4)       el = ELAPSED_W'($urandom_range(0, 60));
        else if (r < 6)  el = ELAPSED_W'($urandom_range(0, 1100));
        else if (r < 8)  el = ELAPSED_W'($urandom);
        else if (r == 8) el = '0;
        else             el = '1;
        send_item(cmd, pick_rate(), pick_rate(), pick_rate(), el);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("gyro_bias_integrate_wrap verification clean");
    else
      $display("gyro_bias_integrate_wrap verification failed");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("gyro_bias_integrate_wrap verification failed");
    $finish;
  end

endmodule

FILE: gyro_bias_integrate_wrap.f
+incdir+rtl/core
rtl/core/gbi_pkg.sv
rtl/core/gbi_regs.sv
rtl/core/gbi_lane.sv
rtl/core/gbi_dp.sv
rtl/core/gbi_ctrl.sv
rtl/core/gyro_bias_integrate_wrap.sv
rtl/core/gbi_checker.sv
tb/sv/gyro_bias_integrate_wrap_checker.sv
tb/sv/tb_gyro_bias_integrate_wrap.sv
